// ===== rtl/montgomery_modular_multiply_macros.svh =====
// Assertion macros for the Montgomery multiplier.
`ifndef MONTGOMERY_MODULAR_MULTIPLY_MACROS_SVH
`define MONTGOMERY_MODULAR_MULTIPLY_MACROS_SVH
`ifndef ASSERT_OFF
`define MMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MMM_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMM_ASSERT(label, prop, msg)
`define MMM_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== rtl/mmm_pkg.sv =====
// Types, constants and command structs of the Montgomery multiplier.
package mmm_pkg;
	localparam int LIMB_BITS = 64;
	localparam int HALF_BITS = LIMB_BITS / 2;
	localparam int MAX_LIMBS = 4;
	localparam int ACC_LEN   = MAX_LIMBS + 2;
	localparam int LIDX_W    = $clog2(MAX_LIMBS);
	localparam int AIDX_W    = $clog2(ACC_LEN + 1);
	localparam int CNT_W     = $clog2(MAX_LIMBS + 1);
	localparam int REG_W     = 3;

	localparam logic [REG_W-1:0] REG_MOD0   = 3'd0;
	localparam logic [REG_W-1:0] REG_MOD1   = 3'd1;
	localparam logic [REG_W-1:0] REG_MOD2   = 3'd2;
	localparam logic [REG_W-1:0] REG_MOD3   = 3'd3;
	localparam logic [REG_W-1:0] REG_FACTOR = 3'd4;
	localparam logic [REG_W-1:0] REG_LIMBS  = 3'd5;

	typedef logic [LIMB_BITS-1:0] limb_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_POST, ST_CARRY, ST_SHIFT, ST_SUB, ST_OUT
	} state_t;

	typedef enum logic [1:0] {PH_U0, PH_U, PH_YX, PH_MU} phase_t;

	typedef struct packed {
		logic               load;
		logic               clear;
		logic               mul_en;
		phase_t             src;
		logic               set_u0;
		logic               set_u;
		logic               mac;
		logic               carry_add;
		logic               shift;
		logic               sub;
		logic [LIDX_W-1:0]  i;
		logic [AIDX_W-1:0]  j;
		logic [1:0]         k;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
	} status_t;
endpackage

// ===== rtl/mmm_if.sv =====
// Operand and result channels.
interface mmm_in_if;
	import mmm_pkg::*;
	logic  valid;
	logic  ready;
	limb_t x_limb;
	limb_t y_limb;
	modport source (output valid, x_limb, y_limb, input ready);
	modport sink (input valid, x_limb, y_limb, output ready);
endinterface

interface mmm_out_if;
	import mmm_pkg::*;
	logic  valid;
	logic  ready;
	limb_t z_limb;
	logic  last_limb;
	modport source (output valid, z_limb, last_limb, input ready);
	modport sink (input valid, z_limb, last_limb, output ready);
endinterface

// ===== rtl/mmm_ctrl.sv =====
// Sequencer: loads limbs, steps passes, rows, partial products and output.
module mmm_ctrl import mmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output logic    out_last,
	input  status_t status,
	output cmd_t    cmd
);
	state_t            state_q, state_d;
	phase_t            ph_q;
	logic [LIDX_W-1:0] i_q;
	logic [AIDX_W-1:0] j_q;
	logic [1:0]        k_q;
	logic [CNT_W-1:0]  load_count_q;
	logic [LIDX_W-1:0] idx;
	logic [CNT_W-1:0]  cnt_next;
	logic              complete, in_fire, out_fire, row_end, pass_end;

	assign idx      = load_count_q[LIDX_W-1:0];
	assign cnt_next = CNT_W'(idx) + CNT_W'(1);
	assign complete = cnt_next >= status.n;
	assign in_ready = state_q == ST_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign out_valid = state_q == ST_OUT;
	assign out_fire = out_valid && out_ready;
	assign row_end  = (j_q + AIDX_W'(1)) == AIDX_W'(status.n);
	assign pass_end = (CNT_W'(i_q) + CNT_W'(1)) == status.n;
	assign out_last = row_end;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire && complete) state_d = ST_MUL;
			ST_MUL:   if (k_q == 2'd3) state_d = ST_POST;
			ST_POST: begin
				if ((ph_q == PH_YX || ph_q == PH_MU) && row_end) state_d = ST_CARRY;
				else state_d = ST_MUL;
			end
			ST_CARRY: begin
				if (j_q == AIDX_W'(ACC_LEN)) state_d = (ph_q == PH_YX) ? ST_MUL : ST_SHIFT;
			end
			ST_SHIFT: state_d = pass_end ? ST_SUB : ST_MUL;
			ST_SUB:   if (j_q == AIDX_W'(ACC_LEN - 1)) state_d = ST_OUT;
			ST_OUT:   if (out_fire && row_end) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.src       = ph_q;
		cmd.i         = i_q;
		cmd.j         = j_q;
		cmd.k         = k_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.j     = AIDX_W'(idx);
				cmd.load  = in_fire;
				cmd.clear = in_fire && complete;
			end
			ST_MUL:   cmd.mul_en = 1'b1;
			ST_POST: begin
				cmd.set_u0 = ph_q == PH_U0;
				cmd.set_u  = ph_q == PH_U;
				cmd.mac    = ph_q == PH_YX || ph_q == PH_MU;
			end
			ST_CARRY: cmd.carry_add = j_q != AIDX_W'(ACC_LEN);
			ST_SHIFT: cmd.shift = 1'b1;
			ST_SUB:   cmd.sub = 1'b1;
			ST_OUT:   ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ph_q         <= PH_U0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			load_count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (complete) begin
							load_count_q <= '0;
							i_q          <= '0;
							j_q          <= '0;
							k_q          <= '0;
							ph_q         <= PH_U0;
						end else begin
							load_count_q <= cnt_next;
						end
					end
				end
				ST_MUL: k_q <= k_q + 2'd1;
				ST_POST: begin
					case (ph_q)
						PH_U0:   ph_q <= PH_U;
						PH_U: begin
							ph_q <= PH_YX;
							j_q  <= '0;
						end
						default: j_q <= j_q + AIDX_W'(1);
					endcase
				end
				ST_CARRY: begin
					if (j_q == AIDX_W'(ACC_LEN)) begin
						ph_q <= PH_MU;
						j_q  <= '0;
					end else begin
						j_q <= j_q + AIDX_W'(1);
					end
				end
				ST_SHIFT: begin
					i_q  <= i_q + LIDX_W'(1);
					ph_q <= PH_U0;
					j_q  <= '0;
				end
				ST_SUB: begin
					if (j_q == AIDX_W'(ACC_LEN - 1)) j_q <= '0;
					else j_q <= j_q + AIDX_W'(1);
				end
				ST_OUT: if (out_fire) j_q <= j_q + AIDX_W'(1);
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/mmm_dp.sv =====
// Datapath: config registers, operand stores, 32x32 multiplier, accumulator.
module mmm_dp import mmm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [REG_W-1:0] wr_index,
	input  limb_t            wr_data,
	input  limb_t            x_limb,
	input  limb_t            y_limb,
	input  cmd_t             cmd,
	output status_t          status,
	output limb_t            z_limb
);
	limb_t                  modulus_q [MAX_LIMBS];
	limb_t                  factor_q;
	logic [2:0]             limbs_q;
	limb_t                  x_q [MAX_LIMBS];
	limb_t                  y_q [MAX_LIMBS];
	limb_t                  acc_q [ACC_LEN];
	limb_t                  diff_q [ACC_LEN];
	limb_t                  carry_q, u0_q, u_q;
	logic                   borrow_q;
	logic [2*LIMB_BITS-1:0] p_q;

	logic [LIDX_W-1:0]      jl;
	limb_t                  ma, mb, acc_j, row_carry, sub_b;
	logic [HALF_BITS-1:0]   ha, hb;
	logic [LIMB_BITS-1:0]   pp;
	logic [2*LIMB_BITS-1:0] pp_sh, mac_sum;
	logic [LIMB_BITS:0]     carry_sum, diff;
	logic                   sub_borrow;

	assign jl    = cmd.j[LIDX_W-1:0];
	assign acc_j = acc_q[cmd.j];

	always_comb begin
		if (limbs_q == 3'd0) status.n = CNT_W'(1);
		else if (limbs_q > 3'(MAX_LIMBS)) status.n = CNT_W'(MAX_LIMBS);
		else status.n = CNT_W'(limbs_q);
	end

	always_comb begin
		case (cmd.src)
			PH_U0: begin ma = x_q[cmd.i]; mb = y_q[0]; end
			PH_U:  begin ma = u0_q; mb = factor_q; end
			PH_YX: begin ma = y_q[jl]; mb = x_q[cmd.i]; end
			default: begin ma = modulus_q[jl]; mb = u_q; end
		endcase
		ha = cmd.k[1] ? ma[LIMB_BITS-1:HALF_BITS] : ma[HALF_BITS-1:0];
		hb = cmd.k[0] ? mb[LIMB_BITS-1:HALF_BITS] : mb[HALF_BITS-1:0];
		pp = LIMB_BITS'(ha) * LIMB_BITS'(hb);
		case (cmd.k)
			2'd0:    pp_sh = {{LIMB_BITS{1'b0}}, pp};
			2'd3:    pp_sh = {pp, {LIMB_BITS{1'b0}}};
			default: pp_sh = {{HALF_BITS{1'b0}}, pp, {HALF_BITS{1'b0}}};
		endcase
	end

	// row carry starts from zero on the first limb
	assign row_carry  = (cmd.j == '0) ? '0 : carry_q;
	assign mac_sum    = {{LIMB_BITS{1'b0}}, acc_j} + p_q + {{LIMB_BITS{1'b0}}, row_carry};
	assign carry_sum  = {1'b0, acc_j} + {1'b0, carry_q};
	assign sub_b      = (cmd.j < AIDX_W'(status.n)) ? modulus_q[jl] : '0;
	assign sub_borrow = (cmd.j == '0) ? 1'b0 : borrow_q;
	assign diff       = {1'b0, acc_j} - {1'b0, sub_b} - (LIMB_BITS + 1)'(sub_borrow);

	// final borrow clear means the accumulator was at least m
	assign z_limb = borrow_q ? acc_j : diff_q[cmd.j];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_LIMBS; r++) modulus_q[r] <= '0;
			factor_q <= '0;
			limbs_q  <= 3'(MAX_LIMBS);
		end else if (wr_en) begin
			unique case (wr_index) inside
				REG_MOD0, REG_MOD1, REG_MOD2, REG_MOD3:
					modulus_q[wr_index[LIDX_W-1:0]] <= wr_data;
				REG_FACTOR: factor_q <= wr_data;
				REG_LIMBS:  limbs_q  <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[jl] <= x_limb;
			y_q[jl] <= y_limb;
		end
		if (cmd.clear) begin
			for (int r = 0; r < ACC_LEN; r++) acc_q[r] <= '0;
		end
		if (cmd.mul_en) p_q <= (cmd.k == 2'd0) ? pp_sh : p_q + pp_sh;
		if (cmd.set_u0) u0_q <= acc_q[0] + p_q[LIMB_BITS-1:0];
		if (cmd.set_u) u_q <= p_q[LIMB_BITS-1:0];
		if (cmd.mac) begin
			acc_q[cmd.j] <= mac_sum[LIMB_BITS-1:0];
			carry_q      <= mac_sum[2*LIMB_BITS-1:LIMB_BITS];
		end
		if (cmd.carry_add) begin
			acc_q[cmd.j] <= carry_sum[LIMB_BITS-1:0];
			carry_q      <= LIMB_BITS'(carry_sum[LIMB_BITS]);
		end
		if (cmd.shift) begin
			for (int r = 0; r < ACC_LEN - 1; r++) acc_q[r] <= acc_q[r+1];
			acc_q[ACC_LEN-1] <= '0;
		end
		if (cmd.sub) begin
			diff_q[cmd.j] <= diff[LIMB_BITS-1:0];
			borrow_q      <= diff[LIMB_BITS];
		end
	end
endmodule

// ===== rtl/montgomery_modular_multiply.sv =====
// Montgomery multiplier: z = x*y*R^-1 mod m, R = 2^(64n), n = 1..4 limbs.
// Feed n operand words (x and y limbs, least significant first); the last one
// starts the product and no further word is taken until all n result words,
// least significant first with last_limb on the top one, have been taken.
// Every 64x64 limb product runs on one shared 32x32 multiplier as four partial
// products and is then accumulated; a final subtract over six accumulator limbs
// follows the n passes. Write configuration only while idle.
`include "montgomery_modular_multiply_macros.svh"
module montgomery_modular_multiply import mmm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [REG_W-1:0] wr_index,
	input  limb_t            wr_data,
	mmm_in_if.sink           operand,
	mmm_out_if.source        result
);
	cmd_t    cmd;
	status_t status;

	mmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_last  (result.last_limb),
		.status    (status),
		.cmd       (cmd)
	);

	mmm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.x_limb   (operand.x_limb),
		.y_limb   (operand.y_limb),
		.cmd      (cmd),
		.status   (status),
		.z_limb   (result.z_limb)
	);

	`MMM_ASSERT(a_no_overlap, !(result.valid && operand.ready), "input open while results pending")
	`MMM_ASSERT(a_last_idle, result.valid && result.ready && result.last_limb |=> operand.ready, "not idle after last word")
	`MMM_ASSERT(a_one_op, !(cmd.mac && cmd.carry_add) && !(cmd.shift && cmd.mac), "conflicting accumulator writes")
	`MMM_ASSERT_RST(a_reset_quiet, !arst_n |-> !result.valid, "result valid in reset")
endmodule

// ===== tb/montgomery_modular_multiply_test.sv =====
// Self-checking testbench for the Montgomery multiplier: directed rows, then random products.
module montgomery_modular_multiply_test;
	import mmm_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE       = 300;
	localparam int RANDOM_WORDS = 430;
	localparam logic [REG_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_W-1:0] REG_SPARE_HI = 3'd7;
	localparam limb_t ONES = '1;

	typedef struct packed {
		limb_t z;
		logic  last;
	} z_word_t;

	typedef struct {
		limb_t x;
		limb_t y;
		bit    known;
		limb_t z;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [REG_W-1:0] wr_index;
	limb_t            wr_data;

	mmm_in_if  operand_ch ();
	mmm_out_if result_ch ();

	montgomery_modular_multiply u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.operand  (operand_ch.sink),
		.result   (result_ch.source)
	);

	// shadow copy of the block
	limb_t      mod_limb [MAX_LIMBS];
	limb_t      factor;
	logic [2:0] limbs_raw;
	limb_t      x_keep [MAX_LIMBS];
	limb_t      y_keep [MAX_LIMBS];
	int         fill;

	z_word_t pending_z [$];
	int      errors;
	int      cycles;
	int      words_sent;
	int      words_checked;
	int      products;
	bit      steady;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_n();
		if (limbs_raw == 3'd0)
			return 1;
		if (limbs_raw > MAX_LIMBS)
			return MAX_LIMBS;
		return int'(limbs_raw);
	endfunction

	function automatic limb_t neg_inverse(limb_t m0);
		limb_t inv;
		inv = m0;
		for (int k = 0; k < 6; k++)
			inv = inv * (64'd2 - m0 * inv);
		return -inv;
	endfunction

	// takes one operand word; queues the product words when it is the last one
	function automatic void load_pair(limb_t x, limb_t y);
		logic [383:0] acc;
		logic [255:0] yv, mv;
		logic [127:0] prod;
		limb_t        t, u;
		int           n, idx;
		n = active_n();
		idx = fill % MAX_LIMBS;
		x_keep[idx] = x;
		y_keep[idx] = y;
		fill = idx + 1;
		if (fill < n)
			return;
		fill = 0;
		products++;
		acc = '0;
		yv = '0;
		mv = '0;
		for (int j = 0; j < n; j++) begin
			yv[j*64 +: 64] = y_keep[j];
			mv[j*64 +: 64] = mod_limb[j];
		end
		for (int i = 0; i < n; i++) begin
			prod = {64'd0, x_keep[i]} * {64'd0, y_keep[0]};
			t = acc[63:0] + prod[63:0];
			prod = {64'd0, t} * {64'd0, factor};
			u = prod[63:0];
			acc = acc + ({128'd0, yv} * {320'd0, x_keep[i]})
				+ ({128'd0, mv} * {320'd0, u});
			acc = acc >> 64;
		end
		// full accumulator against m, one subtraction at most
		if (acc >= {128'd0, mv})
			acc = acc - {128'd0, mv};
		for (int k = 0; k < n; k++)
			pending_z.push_back('{z: acc[k*64 +: 64], last: (k == n - 1)});
	endfunction

	task automatic write_reg(logic [REG_W-1:0] idx, limb_t value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		case (idx) inside
			REG_MOD0, REG_MOD1, REG_MOD2, REG_MOD3: mod_limb[idx] = value;
			REG_FACTOR: factor = value;
			REG_LIMBS: limbs_raw = value[2:0];
			default: ;
		endcase
	endtask

	task automatic setup(limb_t m0, limb_t m1, limb_t m2, limb_t m3, limb_t f,
			logic [2:0] nraw);
		write_reg(REG_MOD0, m0);
		write_reg(REG_MOD1, m1);
		write_reg(REG_MOD2, m2);
		write_reg(REG_MOD3, m3);
		write_reg(REG_FACTOR, f);
		write_reg(REG_LIMBS, {$urandom, $urandom} & ~64'd7 | {61'd0, nraw});
		if ($urandom_range(1))
			write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// one word on the operand channel; returns after the handshake
	task automatic send_word(limb_t x, limb_t y, bit known = 0, limb_t z = '0);
		while (!steady && $urandom_range(99) < 21) begin
			operand_ch.valid <= 1'b0;
			@(posedge clk);
		end
		operand_ch.valid <= 1'b1;
		operand_ch.x_limb <= x;
		operand_ch.y_limb <= y;
		do
			@(posedge clk);
		while (!operand_ch.ready);
		load_pair(x, y);
		if (known)
			pending_z[$].z = z;
		words_sent++;
	endtask

	task automatic drain();
		operand_ch.valid <= 1'b0;
		while (pending_z.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic limb_t pick_limb();
		case ($urandom_range(9))
			0: return '0;
			1: return ONES;
			2: return 64'd1;
			3: return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// result side: random back-pressure and in-order check
	always @(posedge clk or negedge arst_n) begin
		z_word_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_z.size() == 0) begin
					$display("%0t: unexpected word z=%h last=%b", $time,
						result_ch.z_limb, result_ch.last_limb);
					errors++;
				end else begin
					want = pending_z.pop_front();
					if (result_ch.z_limb !== want.z) begin
						$display("%0t: z_limb expected %h actual %h", $time, want.z,
							result_ch.z_limb);
						errors++;
					end
					if (result_ch.last_limb !== want.last) begin
						$display("%0t: last_limb expected %b actual %b", $time, want.last,
							result_ch.last_limb);
						errors++;
					end
				end
				words_checked++;
			end
			result_ch.ready <= steady || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: run timed out, %0d words still due", $time, pending_z.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		row_t  rows [$];
		limb_t m [MAX_LIMBS];
		limb_t f;
		int    budget, cnt;
		logic [2:0] nraw;

		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		operand_ch.valid = 1'b0;
		operand_ch.x_limb = '0;
		operand_ch.y_limb = '0;
		errors = 0;
		cycles = 0;
		words_sent = 0;
		words_checked = 0;
		products = 0;
		steady = 0;
		for (int j = 0; j < MAX_LIMBS; j++) begin
			mod_limb[j] = '0;
			x_keep[j] = '0;
			y_keep[j] = '0;
		end
		factor = '0;
		limbs_raw = 3'd4;
		fill = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero modulus, zero factor, four words
		send_word(ONES, ONES);
		send_word(ONES, 64'd0);
		send_word(64'd0, ONES);
		send_word(64'h8000_0000_0000_0000, 64'd1);
		drain();

		// single word, largest odd modulus; a zero operand gives zero
		setup(ONES, '0, '0, '0, neg_inverse(ONES), 3'd1);
		rows = '{
			'{x: 64'd0, y: 64'd0, known: 1, z: 64'd0},
			'{x: 64'd0, y: ONES, known: 1, z: 64'd0},
			'{x: ONES, y: 64'd0, known: 1, z: 64'd0},
			'{x: ONES, y: ONES, known: 0, z: 64'd0},
			'{x: 64'd1, y: 64'd1, known: 0, z: 64'd0},
			'{x: ONES, y: 64'd1, known: 0, z: 64'd0},
			'{x: 64'h8000_0000_0000_0000, y: 64'd3, known: 0, z: 64'd0}
		};
		foreach (rows[r])
			send_word(rows[r].x, rows[r].y, rows[r].known, rows[r].z);
		drain();

		// four words, all-ones modulus, then even modulus with wrong factor
		setup(ONES, ONES, ONES, ONES, neg_inverse(ONES), 3'd4);
		for (int k = 0; k < 4; k++)
			send_word(ONES, ONES);
		drain();
		setup(64'd2, '0, '0, 64'd1, ONES, 3'd7);
		for (int k = 0; k < 4; k++)
			send_word(ONES, k[0] ? ONES : 64'd0);
		drain();

		// random setups; leftover partial loads carry into the next setup
		budget = RANDOM_WORDS;
		while (budget > 0) begin
			for (int j = 0; j < MAX_LIMBS; j++)
				m[j] = pick_limb();
			if ($urandom_range(7) != 0)
				m[0][0] = 1'b1;
			f = ($urandom_range(5) == 0) ? pick_limb() : neg_inverse(m[0]);
			nraw = 3'($urandom_range(7));
			// first setup always runs with no idling on either side
			steady = (budget == RANDOM_WORDS) || ($urandom_range(5) == 0);
			setup(m[0], m[1], m[2], m[3], f, nraw);
			cnt = $urandom_range(2, 24);
			if (cnt > budget)
				cnt = budget;
			for (int k = 0; k < cnt; k++)
				send_word(pick_limb(), pick_limb());
			budget -= cnt;
			drain();
		end
		steady = 0;

		$display("%0d operand words in, %0d products, %0d result words checked",
			words_sent, products, words_checked);
		$display("limb counts 0..7 written, odd/even moduli, right and wrong factors");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
